// ===== rtl/core/halpb_pkg.sv =====
// ----------------------------------------------------------------------------
// halpb_pkg
// Shared types and constants of the height-aware lru page buffer unit.
// ----------------------------------------------------------------------------
`default_nettype none

package halpb_pkg;

    // slot table geometry
    localparam int SLOTS          = 16;
    localparam int IW             = $clog2(SLOTS);
    localparam int CNTW           = $clog2(SLOTS + 1);
    localparam int ENTRY_OVERHEAD = 8;
    localparam int COSTW          = 17;
    localparam int NEEDW          = COSTW + 1;
    localparam int SUMW           = COSTW + IW;

    // request modes
    localparam logic [1:0] MODE_GET    = 2'd0;
    localparam logic [1:0] MODE_PUT    = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // result status codes
    localparam logic [3:0] ST_EVICT   = 4'd0;
    localparam logic [3:0] ST_HIT     = 4'd1;
    localparam logic [3:0] ST_STORED  = 4'd2;
    localparam logic [3:0] ST_NOSTORE = 4'd3;
    localparam logic [3:0] ST_RESIZED = 4'd4;
    localparam logic [3:0] ST_REMOVED = 4'd5;
    localparam logic [3:0] ST_NOACT   = 4'd6;
    localparam logic [3:0] ST_CLEARED = 4'd7;
    localparam logic [3:0] ST_NOSLOT  = 4'd8;

    // configuration register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_HEIGHT   = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] page_id;
        logic [3:0]  node_height;
        logic [15:0] page_size;
        logic        modified;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] evicted_page;
        logic [31:0] bytes_used;
        logic [4:0]  entry_count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0]      page;
        logic [3:0]       height;
        logic [COSTW-1:0] cost;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/core/height_aware_lru_page_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// height_aware_lru_page_buffer_unit
// Tag and byte accounting of an lru page buffer with height-aware eviction.
// ----------------------------------------------------------------------------
// Usage: one request item is taken at a time. Page id, height and cost of
// each slot sit in a single-port synchronous ram, valid bits and age ranks
// in flops. A request scans the ram once to find the page; when space is
// short it scans again to sum eligible costs and then walks the age order,
// reading and checking each visited entry, emitting one eviction report
// item per removal before the final item. An output stall holds both the
// eviction reports and the final item. No clearing pass is needed after
// reset.
`default_nettype none

module height_aware_lru_page_buffer_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire halpb_pkg::t_in_item     i_in_item,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output halpb_pkg::t_out_item         o_out_item,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_idx,
    input  wire  [31:0]                  i_cfg_data
);

    localparam int IW    = halpb_pkg::IW;
    localparam int CNTW  = halpb_pkg::CNTW;
    localparam int COSTW = halpb_pkg::COSTW;
    localparam int NEEDW = halpb_pkg::NEEDW;
    localparam int SUMW  = halpb_pkg::SUMW;
    localparam int SLOTS = halpb_pkg::SLOTS;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FIND   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_SUM    = 9'b000001000,
        S_SUMCHK = 9'b000010000,
        S_EVRD   = 9'b000100000,
        S_EVCHK  = 9'b001000000,
        S_AFTER  = 9'b010000000,
        S_EMIT   = 9'b100000000
    } t_state;

    typedef enum logic [2:0] {
        CTX_PUT_HIT  = 3'b001,
        CTX_PUT_MISS = 3'b010,
        CTX_UPD      = 3'b100
    } t_ctx;

    // configuration
    logic [31:0] r_cap;
    logic [3:0]  r_tree;

    // sequencer state
    t_state              r_state, n_state;
    t_ctx                r_ctx, n_ctx;
    halpb_pkg::t_in_item r_req, n_req;
    logic [COSTW-1:0]    r_cost, n_cost;
    logic [IW:0]         r_scan, n_scan;
    logic                r_hit, n_hit;
    logic [IW-1:0]       r_hit_idx, n_hit_idx;
    logic [COSTW-1:0]    r_hit_cost, n_hit_cost;
    logic [3:0]          r_hit_height, n_hit_height;
    logic                r_skip_en, n_skip_en;
    logic signed [NEEDW-1:0] r_need, n_need;
    logic [SUMW-1:0]     r_sum, n_sum;
    logic [CNTW-1:0]     r_p, n_p;
    logic [IW-1:0]       r_s, n_s;
    logic                r_ok, n_ok;
    logic [3:0]          r_status, n_status;

    // slot bookkeeping in flops
    logic [SLOTS-1:0]    r_valid, n_valid;
    logic [IW-1:0]       r_rank [SLOTS];
    logic [IW-1:0]       n_rank [SLOTS];
    logic [31:0]         r_used, n_used;
    logic [CNTW-1:0]     r_count, n_count;

    // slot ram
    halpb_pkg::t_entry   r_mem [SLOTS];
    halpb_pkg::t_entry   r_q;
    logic                rd_en, wr_en;
    logic [IW-1:0]       rd_addr, wr_addr;
    halpb_pkg::t_entry   wr_data;

    // output register
    halpb_pkg::t_out_item r_out, out_d;
    logic                r_out_vld, out_load, out_free;

    // helpers
    logic                act_mru, act_rm, act_ins, act_apply;
    logic [IW-1:0]       rm_idx;
    logic [COSTW-1:0]    rm_cost;
    logic                free_found;
    logic [IW-1:0]       free_idx;
    logic                age_found;
    logic [IW-1:0]       age_idx;
    logic [IW-1:0]       scan_idx;
    logic signed [NEEDW-1:0] diff, cost_s, chk_need;
    logic signed [34:0]  lhs, rhs;
    logic                fits;
    logic                q_elig;
    logic                mod_eff;
    logic                too_big;

    assign out_free = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_item = r_out;
    assign o_in_stall = (r_state != S_IDLE);

    assign scan_idx = IW'(r_scan - (IW+1)'(1));
    assign cost_s   = $signed({1'b0, r_cost});
    assign diff     = $signed({1'b0, r_cost}) - $signed({1'b0, r_hit_cost});
    assign chk_need = (r_state == S_EVRD) ? r_need : (r_hit ? diff : cost_s);
    assign lhs      = $signed({3'b000, r_cap});
    assign rhs      = $signed({3'b000, r_used})
                    + $signed({{(35-NEEDW){chk_need[NEEDW-1]}}, chk_need});
    assign fits     = (lhs >= rhs);
    assign mod_eff  = (r_req.mode == halpb_pkg::MODE_PUT) && r_req.modified;
    assign too_big  = (r_cap == 32'd0) || (r_cap < {{(32-COSTW){1'b0}}, r_cost});

    // eligibility of the entry just read
    always_comb begin
        q_elig = (r_req.node_height >= r_q.height) || (r_q.height > r_tree);
    end

    // first free slot, lowest index wins
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                free_found = 1'b1;
                free_idx   = IW'(j);
            end
        end
    end

    // slot holding the current age position
    always_comb begin
        age_found = 1'b0;
        age_idx   = '0;
        for (int j = 0; j < SLOTS; j++) begin
            if (r_valid[j] && ({1'b0, r_rank[j]} == r_p)) begin
                age_found = 1'b1;
                age_idx   = IW'(j);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_ctx        = r_ctx;
        n_req        = r_req;
        n_cost       = r_cost;
        n_scan       = r_scan;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_cost   = r_hit_cost;
        n_hit_height = r_hit_height;
        n_skip_en    = r_skip_en;
        n_need       = r_need;
        n_sum        = r_sum;
        n_p          = r_p;
        n_s          = r_s;
        n_ok         = r_ok;
        n_status     = r_status;
        n_valid      = r_valid;
        n_rank       = r_rank;
        n_used       = r_used;
        n_count      = r_count;
        act_mru      = 1'b0;
        act_rm       = 1'b0;
        act_ins      = 1'b0;
        act_apply    = 1'b0;
        rm_idx       = r_hit_idx;
        rm_cost      = r_hit_cost;
        rd_en        = 1'b0;
        rd_addr      = r_scan[IW-1:0];
        wr_en        = 1'b0;
        wr_addr      = free_idx;
        wr_data      = '{page: r_req.page_id, height: r_req.node_height, cost: r_cost};
        out_load     = 1'b0;
        out_d        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req  = i_in_item;
                    n_cost = COSTW'(i_in_item.page_size) + COSTW'(halpb_pkg::ENTRY_OVERHEAD);
                    n_hit  = 1'b0;
                    n_scan = '0;
                    if (i_in_item.mode == halpb_pkg::MODE_CLEAR) begin
                        n_valid  = '0;
                        n_used   = '0;
                        n_count  = '0;
                        n_status = halpb_pkg::ST_CLEARED;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                rd_en = (r_scan < (IW+1)'(SLOTS));
                if (r_scan != '0) begin
                    if (r_valid[scan_idx] && r_q.page == r_req.page_id) begin
                        n_hit        = 1'b1;
                        n_hit_idx    = scan_idx;
                        n_hit_cost   = r_q.cost;
                        n_hit_height = r_q.height;
                    end
                end
                n_scan = r_scan + (IW+1)'(1);
                if (r_scan == (IW+1)'(SLOTS)) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state   = S_EMIT;
                n_scan    = '0;
                n_sum     = '0;
                n_skip_en = 1'b0;
                if (r_req.mode == halpb_pkg::MODE_UPDATE) begin
                    if (!r_hit) begin
                        n_status = halpb_pkg::ST_NOACT;
                    end else if (fits) begin
                        act_apply = 1'b1;
                        n_status  = halpb_pkg::ST_RESIZED;
                    end else begin
                        n_need    = diff;
                        n_skip_en = 1'b1;
                        n_ctx     = CTX_UPD;
                        n_state   = S_SUM;
                    end
                end else if (r_req.mode == halpb_pkg::MODE_GET && r_hit) begin
                    act_mru  = 1'b1;
                    n_status = halpb_pkg::ST_HIT;
                end else if (too_big) begin
                    n_status = halpb_pkg::ST_NOSTORE;
                end else if (r_hit) begin
                    if (!mod_eff) begin
                        n_status = halpb_pkg::ST_NOACT;
                    end else if (fits) begin
                        act_mru   = 1'b1;
                        act_apply = 1'b1;
                        n_status  = halpb_pkg::ST_RESIZED;
                    end else begin
                        act_rm  = 1'b1;
                        n_need  = cost_s;
                        n_ctx   = CTX_PUT_HIT;
                        n_state = S_SUM;
                    end
                end else if (fits) begin
                    act_ins  = 1'b1;
                    n_status = free_found ? halpb_pkg::ST_STORED : halpb_pkg::ST_NOSLOT;
                end else begin
                    n_need  = cost_s;
                    n_ctx   = CTX_PUT_MISS;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                rd_en = (r_scan < (IW+1)'(SLOTS));
                if (r_scan != '0) begin
                    if (r_valid[scan_idx] && q_elig
                        && !(r_skip_en && scan_idx == r_hit_idx)) begin
                        n_sum = r_sum + SUMW'(r_q.cost);
                    end
                end
                n_scan = r_scan + (IW+1)'(1);
                if (r_scan == (IW+1)'(SLOTS)) n_state = S_SUMCHK;
            end
            S_SUMCHK: begin
                n_p = '0;
                if ($signed({2'b00, r_sum})
                    < $signed({{(SUMW+2-NEEDW){r_need[NEEDW-1]}}, r_need})) begin
                    n_ok    = 1'b0;
                    n_state = S_AFTER;
                end else begin
                    n_state = S_EVRD;
                end
            end
            S_EVRD: begin
                if (fits || !age_found) begin
                    n_ok    = 1'b1;
                    n_state = S_AFTER;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = age_idx;
                    n_s     = age_idx;
                    n_state = S_EVCHK;
                end
            end
            S_EVCHK: begin
                if (q_elig && !(r_skip_en && r_s == r_hit_idx)) begin
                    if (out_free) begin
                        act_rm   = 1'b1;
                        rm_idx   = r_s;
                        rm_cost  = r_q.cost;
                        out_load = 1'b1;
                        out_d    = '{status: halpb_pkg::ST_EVICT, evicted_page: r_q.page,
                                     bytes_used: r_used - {{(32-COSTW){1'b0}}, r_q.cost},
                                     entry_count: r_count - CNTW'(1), last: 1'b0};
                        n_state  = S_EVRD;
                    end
                end else begin
                    n_p     = r_p + CNTW'(1);
                    n_state = S_EVRD;
                end
            end
            S_AFTER: begin
                n_state = S_EMIT;
                unique case (r_ctx)
                    CTX_PUT_HIT: begin
                        if (r_ok) begin
                            act_ins  = 1'b1;
                            n_status = free_found ? halpb_pkg::ST_RESIZED : halpb_pkg::ST_NOSLOT;
                        end else begin
                            n_status = halpb_pkg::ST_REMOVED;
                        end
                    end
                    CTX_PUT_MISS: begin
                        if (r_ok) begin
                            act_ins  = 1'b1;
                            n_status = free_found ? halpb_pkg::ST_STORED : halpb_pkg::ST_NOSLOT;
                        end else begin
                            n_status = halpb_pkg::ST_NOSTORE;
                        end
                    end
                    CTX_UPD: begin
                        if (r_ok) begin
                            act_apply = 1'b1;
                            n_status  = halpb_pkg::ST_RESIZED;
                        end else begin
                            act_rm   = 1'b1;
                            n_status = halpb_pkg::ST_REMOVED;
                        end
                    end
                    default: n_status = r_status;
                endcase
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_d    = '{status: r_status, evicted_page: 32'd0, bytes_used: r_used,
                                 entry_count: r_count, last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // move hit entry to most recent
        if (act_mru) begin
            for (int j = 0; j < SLOTS; j++) begin
                if (r_valid[j] && r_rank[j] > r_rank[r_hit_idx]) n_rank[j] = r_rank[j] - IW'(1);
            end
            n_rank[r_hit_idx] = IW'(r_count - CNTW'(1));
        end
        // drop one entry and close the age gap
        if (act_rm) begin
            for (int j = 0; j < SLOTS; j++) begin
                if (r_valid[j] && r_rank[j] > r_rank[rm_idx]) n_rank[j] = r_rank[j] - IW'(1);
            end
            n_valid[rm_idx] = 1'b0;
            n_used          = r_used - {{(32-COSTW){1'b0}}, rm_cost};
            n_count         = r_count - CNTW'(1);
        end
        // insert at most recent
        if (act_ins && free_found) begin
            n_rank[free_idx]  = IW'(r_count);
            n_valid[free_idx] = 1'b1;
            n_used            = r_used + {{(32-COSTW){1'b0}}, r_cost};
            n_count           = r_count + CNTW'(1);
            wr_en             = 1'b1;
        end
        // resize in place, height kept
        if (act_apply) begin
            n_used  = r_used + {{(32-NEEDW){diff[NEEDW-1]}}, diff};
            wr_en   = 1'b1;
            wr_addr = r_hit_idx;
            wr_data = '{page: r_req.page_id, height: r_hit_height, cost: r_cost};
        end
    end

    // slot ram, registered read data
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_q <= r_mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_cost       <= n_cost;
        r_scan       <= n_scan;
        r_hit_idx    <= n_hit_idx;
        r_hit_cost   <= n_hit_cost;
        r_hit_height <= n_hit_height;
        r_need       <= n_need;
        r_sum        <= n_sum;
        r_p          <= n_p;
        r_s          <= n_s;
        r_ok         <= n_ok;
        r_status     <= n_status;
        r_rank       <= n_rank;
        r_skip_en    <= n_skip_en;
        r_hit        <= n_hit;
        r_ctx        <= n_ctx;
        if (out_load) r_out <= out_d;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_used    <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_cap     <= '0;
            r_tree    <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_used  <= n_used;
            r_count <= n_count;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    halpb_pkg::CFG_CAPACITY: r_cap  <= i_cfg_data;
                    halpb_pkg::CFG_HEIGHT:   r_tree <= i_cfg_data[3:0];
                    default:                 r_cap  <= r_cap;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    // entry count tracks the valid bits
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNTW'($countones(r_valid)))
        else $error("entry count out of step with valid bits");

    // an accepted item makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted item did not start work");

    // eviction reports never close a request
    a_evict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == halpb_pkg::ST_EVICT |-> !o_out_item.last)
        else $error("eviction report marked last");

    // the final item returns the sequencer to idle
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && out_free |=> r_state == S_IDLE)
        else $error("final item did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== test/tb_height_aware_lru_page_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_height_aware_lru_page_buffer_unit
// Self-checking bench: a behavioural model of the lru page store predicts the
// eviction reports and final item of every request; random gaps on both
// sides, several budget and height settings written between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_height_aware_lru_page_buffer_unit;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    halpb_pkg::t_in_item  i_in_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    halpb_pkg::t_out_item o_out_item;
    logic                 i_cfg_we;
    logic                 i_cfg_idx;
    logic [31:0]          i_cfg_data;

    height_aware_lru_page_buffer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    localparam int SLOTS = halpb_pkg::SLOTS;
    localparam int COSTW = halpb_pkg::COSTW;

    // model state
    logic [31:0]      mdl_capacity;
    logic [3:0]       mdl_tree_h;
    logic             pg_valid [SLOTS];
    logic [31:0]      pg_id    [SLOTS];
    logic [3:0]       pg_h     [SLOTS];
    logic [COSTW-1:0] pg_cost  [SLOTS];
    int unsigned      pg_rank  [SLOTS];
    logic [31:0]      mdl_used;

    halpb_pkg::t_in_item  pending_items [$];
    halpb_pkg::t_out_item awaited_results [$];
    int        fail_count;
    int        cycle_count;
    int        in_gap;
    int        out_gap;
    logic      feed_done;

    localparam int CYCLE_LIMIT = 2000000;

    function automatic int resident_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) if (pg_valid[i]) n++;
        return n;
    endfunction

    function automatic int locate(logic [31:0] id);
        for (int i = 0; i < SLOTS; i++) if (pg_valid[i] && pg_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void push_result(logic [3:0] st, logic [31:0] pg, logic lst);
        halpb_pkg::t_out_item r;
        r.status       = st;
        r.evicted_page = pg;
        r.bytes_used   = mdl_used;
        r.entry_count  = 5'(resident_count());
        r.last         = lst;
        awaited_results.push_back(r);
    endfunction

    function automatic void drop_slot(int s);
        for (int j = 0; j < SLOTS; j++)
            if (pg_valid[j] && pg_rank[j] > pg_rank[s]) pg_rank[j]--;
        pg_valid[s] = 1'b0;
        mdl_used    = mdl_used - 32'(pg_cost[s]);
    endfunction

    function automatic void make_newest(int s);
        int n;
        n = resident_count();
        for (int j = 0; j < SLOTS; j++)
            if (pg_valid[j] && pg_rank[j] > pg_rank[s]) pg_rank[j]--;
        pg_rank[s] = n - 1;
    endfunction

    function automatic logic place_page(logic [31:0] id, logic [3:0] h, logic [COSTW-1:0] c);
        for (int i = 0; i < SLOTS; i++) begin
            if (!pg_valid[i]) begin
                pg_rank[i]  = resident_count();
                pg_valid[i] = 1'b1;
                pg_id[i]    = id;
                pg_h[i]     = h;
                pg_cost[i]  = c;
                mdl_used    = mdl_used + 32'(c);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic evictable(int s, logic [3:0] h, int skip);
        if (s == skip) return 1'b0;
        return (h >= pg_h[s]) || (pg_h[s] > mdl_tree_h);
    endfunction

    // free need bytes by evicting eligible pages oldest first
    function automatic logic free_space(longint need, logic [3:0] h, int skip);
        int     order [SLOTS];
        int     n;
        int     s;
        longint avail;
        n     = 0;
        avail = 0;
        for (int r = 0; r < SLOTS; r++)
            for (int i = 0; i < SLOTS; i++)
                if (pg_valid[i] && pg_rank[i] == r) begin
                    order[n] = i;
                    n++;
                end
        for (int r = 0; r < n; r++)
            if (evictable(order[r], h, skip)) avail += longint'(pg_cost[order[r]]);
        if (avail < need) return 1'b0;
        for (int r = 0; r < n; r++) begin
            s = order[r];
            if (longint'(mdl_capacity) >= longint'(mdl_used) + need) break;
            if (evictable(s, h, skip)) begin
                drop_slot(s);
                push_result(halpb_pkg::ST_EVICT, pg_id[s], 1'b0);
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [3:0] store_page(logic [31:0] id, logic [3:0] h,
                                               logic [COSTW-1:0] c, logic md);
        int     s;
        longint diff;
        if (mdl_capacity == 0 || mdl_capacity < 32'(c)) return halpb_pkg::ST_NOSTORE;
        s = locate(id);
        if (s >= 0) begin
            if (!md) return halpb_pkg::ST_NOACT;
            diff = longint'(c) - longint'(pg_cost[s]);
            if (longint'(mdl_capacity) >= longint'(mdl_used) + diff) begin
                make_newest(s);
                mdl_used   = 32'(longint'(mdl_used) + diff);
                pg_cost[s] = c;
                return halpb_pkg::ST_RESIZED;
            end
            drop_slot(s);
            if (!free_space(longint'(c), h, -1)) return halpb_pkg::ST_REMOVED;
            return place_page(id, h, c) ? halpb_pkg::ST_RESIZED : halpb_pkg::ST_NOSLOT;
        end
        if (longint'(mdl_capacity) < longint'(mdl_used) + longint'(c))
            if (!free_space(longint'(c), h, -1)) return halpb_pkg::ST_NOSTORE;
        return place_page(id, h, c) ? halpb_pkg::ST_STORED : halpb_pkg::ST_NOSLOT;
    endfunction

    // predict all result items of one request
    function automatic void predict_request(halpb_pkg::t_in_item it);
        logic [COSTW-1:0] c;
        logic [3:0]       st;
        int               s;
        longint           diff;
        c = COSTW'(it.page_size) + COSTW'(halpb_pkg::ENTRY_OVERHEAD);
        case (it.mode)
            halpb_pkg::MODE_GET: begin
                s = locate(it.page_id);
                if (s >= 0) begin
                    make_newest(s);
                    st = halpb_pkg::ST_HIT;
                end else begin
                    st = store_page(it.page_id, it.node_height, c, 1'b0);
                end
            end
            halpb_pkg::MODE_PUT: st = store_page(it.page_id, it.node_height, c, it.modified);
            halpb_pkg::MODE_UPDATE: begin
                s = locate(it.page_id);
                if (s < 0) begin
                    st = halpb_pkg::ST_NOACT;
                end else begin
                    diff = longint'(c) - longint'(pg_cost[s]);
                    st   = halpb_pkg::ST_RESIZED;
                    if (longint'(mdl_capacity) < longint'(mdl_used) + diff &&
                        !free_space(diff, it.node_height, s)) begin
                        drop_slot(s);
                        st = halpb_pkg::ST_REMOVED;
                    end
                    if (st == halpb_pkg::ST_RESIZED) begin
                        mdl_used   = 32'(longint'(mdl_used) + diff);
                        pg_cost[s] = c;
                    end
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) pg_valid[i] = 1'b0;
                mdl_used = '0;
                st = halpb_pkg::ST_CLEARED;
            end
        endcase
        push_result(st, '0, 1'b1);
    endfunction

    // no gap half the time, else mostly short gaps and a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (i_in_valid && !o_in_stall) begin
            predict_request(i_in_item);
            i_in_valid <= 1'b0;
            in_gap     <= pick_gap();
        end else if (!i_in_valid) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
            end else if (pending_items.size() > 0) begin
                i_in_item  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // result monitor with random stall
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap     <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected item %p", $time, o_out_item);
                    fail_count <= fail_count + 1;
                end else if (awaited_results[0] !== o_out_item) begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                             awaited_results[0], o_out_item);
                    fail_count <= fail_count + 1;
                    void'(awaited_results.pop_front());
                end else begin
                    void'(awaited_results.pop_front());
                end
            end
            if (out_gap > 0) begin
                out_gap     <= out_gap - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                out_gap     <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // sample on the falling edge so every update of the rising edge has settled
    task automatic wait_idle();
        while (pending_items.size() > 0 || i_in_valid || awaited_results.size() > 0)
            @(negedge i_clk);
        repeat (4 * SLOTS + 20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == halpb_pkg::CFG_CAPACITY) mdl_capacity = val;
        else mdl_tree_h = val[3:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void queue_req(logic [1:0] m, logic [31:0] id, logic [3:0] h,
                                      logic [15:0] sz, logic md);
        halpb_pkg::t_in_item it;
        it.mode        = m;
        it.page_id     = id;
        it.node_height = h;
        it.page_size   = sz;
        it.modified    = md;
        pending_items.push_back(it);
    endfunction

    // random traffic over a small id pool so hits and evictions are common
    task automatic random_phase(int n, int max_sz);
        logic [31:0] id;
        int          p;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) id = $urandom();
            else id = 32'($urandom_range(0, 23)) ^ 32'hA5A5_0000;
            if (p < 40)
                queue_req(halpb_pkg::MODE_GET, id, 4'($urandom()),
                          16'($urandom_range(0, max_sz)), 1'b0);
            else if (p < 75)
                queue_req(halpb_pkg::MODE_PUT, id, 4'($urandom()),
                          16'($urandom_range(0, max_sz)), 1'($urandom()));
            else if (p < 97)
                queue_req(halpb_pkg::MODE_UPDATE, id, 4'($urandom()),
                          16'($urandom_range(0, max_sz)), 1'($urandom()));
            else
                queue_req(halpb_pkg::MODE_CLEAR, $urandom(), 4'($urandom()),
                          16'($urandom()), 1'b0);
        end
        wait_idle();
    endtask

    initial begin
        fail_count   = 0;
        cycle_count  = 0;
        mdl_capacity = '0;
        mdl_tree_h   = '0;
        mdl_used     = '0;
        for (int i = 0; i < SLOTS; i++) begin
            pg_valid[i] = 1'b0;
            pg_rank[i]  = 0;
        end
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = halpb_pkg::CFG_CAPACITY;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero budget: nothing stored
        queue_req(halpb_pkg::MODE_GET, 32'h0, 4'h0, 16'h0, 1'b0);
        queue_req(halpb_pkg::MODE_PUT, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 1'b1);
        wait_idle();

        // small budget, height 2: insert, hit, resize, no action, update, evict
        write_reg(halpb_pkg::CFG_CAPACITY, 32'd100);
        write_reg(halpb_pkg::CFG_HEIGHT, 32'd2);
        queue_req(halpb_pkg::MODE_PUT, 32'd1, 4'd1, 16'd20, 1'b0);
        queue_req(halpb_pkg::MODE_PUT, 32'd2, 4'd5, 16'd20, 1'b0);
        queue_req(halpb_pkg::MODE_GET, 32'd1, 4'd0, 16'd0, 1'b0);
        queue_req(halpb_pkg::MODE_PUT, 32'd1, 4'd1, 16'd20, 1'b0);
        queue_req(halpb_pkg::MODE_PUT, 32'd1, 4'd1, 16'd30, 1'b1);
        queue_req(halpb_pkg::MODE_UPDATE, 32'd9, 4'd0, 16'd5, 1'b0);
        queue_req(halpb_pkg::MODE_UPDATE, 32'd2, 4'd0, 16'd40, 1'b0);
        queue_req(halpb_pkg::MODE_GET, 32'd3, 4'd0, 16'd60, 1'b0);
        queue_req(halpb_pkg::MODE_PUT, 32'd4, 4'd15, 16'd90, 1'b0);
        queue_req(halpb_pkg::MODE_PUT, 32'd5, 4'd0, 16'd200, 1'b0);
        queue_req(halpb_pkg::MODE_PUT, 32'd4, 4'd0, 16'd91, 1'b1);
        queue_req(halpb_pkg::MODE_CLEAR, 32'd0, 4'd0, 16'd0, 1'b0);
        wait_idle();

        // many tiny pages fill the slot table
        write_reg(halpb_pkg::CFG_CAPACITY, 32'hFFFF_FFFF);
        write_reg(halpb_pkg::CFG_HEIGHT, 32'd15);
        for (int k = 0; k < 18; k++)
            queue_req(halpb_pkg::MODE_PUT, 32'(k + 100), 4'(k), 16'(k), 1'b0);
        wait_idle();

        // budget lowered below usage
        write_reg(halpb_pkg::CFG_CAPACITY, 32'd40);
        queue_req(halpb_pkg::MODE_PUT, 32'd200, 4'd15, 16'd30, 1'b0);
        queue_req(halpb_pkg::MODE_UPDATE, 32'd200, 4'd15, 16'd32, 1'b0);
        wait_idle();

        write_reg(halpb_pkg::CFG_CAPACITY, 32'd400);
        write_reg(halpb_pkg::CFG_HEIGHT, 32'd3);
        random_phase(50, 120);
        write_reg(halpb_pkg::CFG_CAPACITY, 32'd1500);
        write_reg(halpb_pkg::CFG_HEIGHT, 32'd0);
        random_phase(50, 200);
        write_reg(halpb_pkg::CFG_CAPACITY, 32'd150000);
        write_reg(halpb_pkg::CFG_HEIGHT, 32'd15);
        random_phase(44, 65535);
        write_reg(halpb_pkg::CFG_CAPACITY, 32'd60);
        write_reg(halpb_pkg::CFG_HEIGHT, 32'd7);
        random_phase(42, 60);

        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
